[rtl/scv_pkg.sv]
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types, constants and checksum helpers for the sentence checksum
// verifier.
// ----------------------------------------------------------------------------
package scv_pkg;

	localparam int MAX_LINE_DEFAULT = 256;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [8:0] COUNT_CAP = 9'd511;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_XOR = 2'd1,
		MODE_CRC = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_STAR = 3'd1,
		ST_WRONG_LENGTH = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	localparam logic CFG_REG_MODE = 1'b0;

	typedef struct packed {
		status_t status;
		logic [15:0] computed_sum;
		logic [15:0] received_sum;
		logic [8:0] line_length;
	} result_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = {crc[7:0], crc[15:8]};
		r = r ^ {8'h00, b};
		r = r ^ {12'h000, r[7:4]};
		r = r ^ {r[3:0], 12'h000};
		r = r ^ {3'b000, r[7:0], 5'b00000};
		return r;
	endfunction

	// Returns {is_digit, digit value}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = {1'b1, 4'(c - 8'h57)};
		end else begin
			d = 5'b00000;
		end
		return d;
	endfunction

endpackage

[rtl/scv_byte_if.sv]
// ----------------------------------------------------------------------------
// scv_byte_if
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface scv_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

[rtl/scv_result_if.sv]
// ----------------------------------------------------------------------------
// scv_result_if
// Valid/ready channel that carries one line verdict per transaction.
// ----------------------------------------------------------------------------
interface scv_result_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [15:0] computed_sum;
	logic [15:0] received_sum;
	logic [8:0] line_length;

	modport source(output valid, output status, output computed_sum,
		output received_sum, output line_length, input ready);
	modport sink(input valid, input status, input computed_sum,
		input received_sum, input line_length, output ready);
endinterface

[rtl/scv_cfg.sv]
// ----------------------------------------------------------------------------
// scv_cfg
// APB-style register port holding the check mode.
// ----------------------------------------------------------------------------
module scv_cfg import scv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output mode_t                 check_mode
);

	mode_t mode_q;
	logic  reg_sel;

	assign pready = 1'b1;
	assign reg_sel = (paddr[CFG_ADDR_W-1:2] == CFG_REG_MODE);
	assign check_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_XOR;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mode_q <= mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(CFG_DATA_W-2){1'b0}}, mode_q};
		end
	end

endmodule

[rtl/scv_line.sv]
// ----------------------------------------------------------------------------
// scv_line
// Per-line state: held byte, position, checksums and hex parse, with the
// verdict for the line formed from the current state.
// ----------------------------------------------------------------------------
module scv_line import scv_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  mode_t      check_mode,
	output result_t    verdict
);

	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       held_q;
	logic             held_valid_q;
	logic             star_q, star_d;
	logic [7:0]       xor_q, xor_d;
	logic [15:0]      crc_q, crc_d;
	logic [15:0]      hex_q, hex_d;
	logic             hex_ok_q, hex_ok_d;
	logic [8:0]       cas_q, cas_d;
	logic             ovf_q, ovf_d;
	logic [4:0]       dig;
	logic [CMP_W-1:0] pos_ext;

	always_comb begin
		pos_d = pos_q;
		star_d = star_q;
		xor_d = xor_q;
		crc_d = crc_q;
		hex_d = hex_q;
		hex_ok_d = hex_ok_q;
		cas_d = cas_q;
		dig = hex_decode(held_q);
		if (held_valid_q) begin
			if (star_q) begin
				if (cas_q < COUNT_CAP) begin
					cas_d = cas_q + 9'd1;
				end
				if (hex_ok_q && dig[4]) begin
					hex_d = {hex_q[11:0], dig[3:0]};
				end else begin
					hex_ok_d = 1'b0;
				end
			end else if (held_q == CHAR_STAR) begin
				star_d = 1'b1;
			end else if (pos_q != '0) begin
				xor_d = xor_q ^ held_q;
				crc_d = crc_update(crc_q, held_q);
			end
			if (pos_q < POS_MAX) begin
				pos_d = pos_q + POS_W'(1);
			end
		end
		ovf_d = ovf_q || ((POS_W+1)'(pos_d) + (POS_W+1)'(1) >= (POS_W+1)'(MAX_LINE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			star_q <= 1'b0;
			xor_q <= '0;
			crc_q <= '0;
			hex_q <= '0;
			hex_ok_q <= 1'b1;
			cas_q <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			if (rx_byte == CHAR_NEWLINE) begin
				pos_q <= '0;
				held_q <= '0;
				held_valid_q <= 1'b0;
				star_q <= 1'b0;
				xor_q <= '0;
				crc_q <= '0;
				hex_q <= '0;
				hex_ok_q <= 1'b1;
				cas_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				held_q <= rx_byte;
				held_valid_q <= 1'b1;
				star_q <= star_d;
				xor_q <= xor_d;
				crc_q <= crc_d;
				hex_q <= hex_d;
				hex_ok_q <= hex_ok_d;
				cas_q <= cas_d;
				ovf_q <= ovf_d;
			end
		end
	end

	assign pos_ext = CMP_W'(pos_q);

	always_comb begin
		if (ovf_q) begin
			verdict.status = ST_TOO_LONG;
		end else if (!star_q) begin
			verdict.status = ST_NO_STAR;
		end else if (check_mode == MODE_XOR) begin
			if (cas_q != 9'd2) begin
				verdict.status = ST_WRONG_LENGTH;
			end else if (hex_q != {8'h00, xor_q}) begin
				verdict.status = ST_MISMATCH;
			end else begin
				verdict.status = ST_OK;
			end
		end else if (check_mode == MODE_CRC) begin
			if (cas_q != 9'd4) begin
				verdict.status = ST_WRONG_LENGTH;
			end else if (hex_q != crc_q) begin
				verdict.status = ST_MISMATCH;
			end else begin
				verdict.status = ST_OK;
			end
		end else begin
			verdict.status = ST_OK;
		end
		verdict.computed_sum = (check_mode == MODE_CRC) ? crc_q : {8'h00, xor_q};
		verdict.received_sum = hex_q;
		verdict.line_length = (pos_ext > CMP_W'(COUNT_CAP)) ? COUNT_CAP : pos_ext[8:0];
	end

endmodule

[rtl/sentence_checksum_verifier.sv]
// A newline byte is held in the input register until it fires; its verdict is then captured in the result register.
// Throughput: one byte per cycle; a data byte enters even while a finished result waits,
// and a newline waits in the input register only until that result is taken.
// Reset: arst_n clears the line state and both valid flags and sets check_mode to
// XOR-8; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sentence_checksum_verifier
// Checks the XOR-8 or CRC16-CCITT checksum of ASCII sentences, one byte per
// transaction, and reports one verdict per line.
// ----------------------------------------------------------------------------
module sentence_checksum_verifier import scv_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scv_byte_if.sink              rx,
	scv_result_if.source          res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	mode_t      check_mode;
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       nl_s1;
	logic       fire_s1;
	result_t    verdict;
	result_t    res_q;
	logic       res_valid_q;

	scv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.check_mode(check_mode)
	);

	scv_line #(.MAX_LINE(MAX_LINE)) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_s1),
		.rx_byte   (byte_s1),
		.check_mode(check_mode),
		.verdict   (verdict)
	);

	assign nl_s1 = (byte_s1 == CHAR_NEWLINE);
	assign fire_s1 = valid_s1 && (!nl_s1 || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (fire_s1 && nl_s1) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (fire_s1 && nl_s1) begin
			res_q <= verdict;
		end
	end

	assign res.valid = res_valid_q;
	assign res.status = res_q.status;
	assign res.computed_sum = res_q.computed_sum;
	assign res.received_sum = res_q.received_sum;
	assign res.line_length = res_q.line_length;

	a_newline_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && nl_s1 |=> res_valid_q)
		else $error("newline left the pipeline without a result");

	a_data_byte_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !nl_s1 && (!res_valid_q || res.ready) |=> !res_valid_q)
		else $error("a data byte produced a result");

	a_ok_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_OK |-> res_q.line_length != 9'd0)
		else $error("ok verdict on a line with no counted bytes");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input register lost its byte");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Sentence checksum verifier testbench
// Streams framed ASCII sentences, malformed lines and raw noise into the
// verifier under all check modes, predicts the verdict of every line in a
// scoreboard and compares each verdict transaction field by field, with
// random idling on both channels.
// ----------------------------------------------------------------------------
import scv_pkg::*;

typedef logic [7:0] byte_q_t[$];

function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] c);
	logic [15:0] r;
	r = {acc[7:0], acc[15:8]} ^ {8'h00, c};
	r = r ^ (r[7:0] >> 4);
	r = r ^ (r << 12);
	r = r ^ ({8'h00, r[7:0]} << 5);
	return r;
endfunction

class verdict_board;
	mode_t mode;
	logic [8:0] position;
	logic [7:0] held;
	bit held_ok;
	bit star;
	bit hex_ok;
	bit too_long;
	logic [7:0] xor_acc;
	logic [15:0] crc_acc;
	logic [15:0] hex_acc;
	logic [8:0] after_star;
	result_t pending[$];
	int errors;

	function new();
		mode = MODE_XOR;
		errors = 0;
		clear_line();
	endfunction

	function void clear_line();
		position = '0;
		held = '0;
		held_ok = 1'b0;
		star = 1'b0;
		hex_ok = 1'b1;
		too_long = 1'b0;
		xor_acc = '0;
		crc_acc = '0;
		hex_acc = '0;
		after_star = '0;
	endfunction

	function void note_byte(input logic [7:0] c);
		result_t r;
		int nib;
		if (c != CHAR_NEWLINE) begin
			if (held_ok) begin
				if (star) begin
					if (held >= "0" && held <= "9") begin
						nib = held - "0";
					end else if (held >= "A" && held <= "F") begin
						nib = held - "A" + 10;
					end else if (held >= "a" && held <= "f") begin
						nib = held - "a" + 10;
					end else begin
						nib = -1;
					end
					if (after_star < COUNT_CAP) after_star++;
					if (hex_ok && nib >= 0) hex_acc = {hex_acc[11:0], 4'(nib)};
					else hex_ok = 1'b0;
				end else if (held == CHAR_STAR) begin
					star = 1'b1;
				end else if (position != 0) begin
					xor_acc = xor_acc ^ held;
					crc_acc = crc_ccitt_step(crc_acc, held);
				end
				if (position < 9'(MAX_LINE_DEFAULT)) position++;
			end
			held = c;
			held_ok = 1'b1;
			if (int'(position) + 1 >= MAX_LINE_DEFAULT) too_long = 1'b1;
		end else begin
			if (too_long) begin
				r.status = ST_TOO_LONG;
			end else if (!star) begin
				r.status = ST_NO_STAR;
			end else if (mode == MODE_XOR) begin
				if (after_star != 2) r.status = ST_WRONG_LENGTH;
				else if (hex_acc != {8'h00, xor_acc}) r.status = ST_MISMATCH;
				else r.status = ST_OK;
			end else if (mode == MODE_CRC) begin
				if (after_star != 4) r.status = ST_WRONG_LENGTH;
				else if (hex_acc != crc_acc) r.status = ST_MISMATCH;
				else r.status = ST_OK;
			end else begin
				r.status = ST_OK;
			end
			r.computed_sum = (mode == MODE_CRC) ? crc_acc : {8'h00, xor_acc};
			r.received_sum = hex_acc;
			r.line_length = position;
			pending.push_back(r);
			clear_line();
		end
	endfunction

	function void check_verdict(input logic [2:0] st, input logic [15:0] cs,
		input logic [15:0] rs, input logic [8:0] len);
		result_t want;
		if (pending.size() == 0) begin
			$error("verdict with no line pending: status %0d", st);
			errors++;
		end else begin
			want = pending.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (cs !== want.computed_sum) begin
				$error("computed_sum: expected %h, actual %h", want.computed_sum, cs);
				errors++;
			end
			if (rs !== want.received_sum) begin
				$error("received_sum: expected %h, actual %h", want.received_sum, rs);
				errors++;
			end
			if (len !== want.line_length) begin
				$error("line_length: expected %0d, actual %0d", want.line_length, len);
				errors++;
			end
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LIMIT = MAX_LINE_DEFAULT;
	localparam int REG_CHECK_MODE = int'(CFG_REG_MODE);
	localparam int REG_UNUSED = 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 60;
	localparam int SIDE_TX = 0;
	localparam int SIDE_RX = 1;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam mode_t PHASE_MODES[6] = '{MODE_CRC, MODE_NONE, MODE_SPARE, MODE_XOR,
		MODE_CRC, MODE_XOR};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	scv_byte_if rx_ch();
	scv_result_if res_ch();

	verdict_board board;
	bit calm[2];
	int cycles = 0;
	int bytes_sent = 0;

	sentence_checksum_verifier #(.MAX_LINE(LINE_LIMIT)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int idle_cycles(input int side);
		if ($urandom_range(0, 31) == 0) calm[side] = !calm[side];
		return calm[side] ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic byte_q_t to_bytes(input string s);
		byte_q_t q;
		foreach (s[i]) q.push_back(s[i]);
		return q;
	endfunction

	function automatic byte_q_t random_body(input int n, input bit printable,
		input bit allow_star);
		byte_q_t q;
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			do begin
				c = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
			end while (c == CHAR_NEWLINE || (!allow_star && c == CHAR_STAR));
			q.push_back(c);
		end
		return q;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_cycles(SIDE_TX);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_line(input byte_q_t q, input bit with_cr);
		foreach (q[i]) send_byte(q[i]);
		if (with_cr) send_byte(CHAR_CR);
		send_byte(CHAR_NEWLINE);
	endtask

	task automatic send_framed(input byte_q_t body, input int digits, input bit corrupt,
		input bit lower, input bit with_cr);
		logic [7:0] x;
		logic [15:0] crc;
		logic [15:0] value;
		logic [3:0] nib;
		byte_q_t q;
		x = '0;
		crc = '0;
		for (int i = 1; i < body.size(); i++) begin
			x = x ^ body[i];
			crc = crc_ccitt_step(crc, body[i]);
		end
		value = (digits >= 4) ? crc : {8'h00, x};
		if (corrupt) value = value ^ 16'($urandom_range(1, 15));
		q = body;
		q.push_back(CHAR_STAR);
		for (int i = digits - 1; i >= 0; i--) begin
			nib = 4'(value >> (4 * i));
			if (nib < 10) q.push_back(8'("0" + nib));
			else q.push_back(8'((lower ? "a" : "A") + nib - 10));
		end
		send_line(q, with_cr);
	endtask

	task automatic random_line();
		int kind;
		int digits;
		int wrong;
		bit lower;
		byte_q_t body;
		kind = $urandom_range(0, 99);
		lower = $urandom_range(0, 1);
		body = random_body($urandom_range(1, 21), $urandom_range(0, 3) != 0, 1'b0);
		if ($urandom_range(0, 7) != 0) body[0] = "$";
		case (board.mode)
			MODE_CRC: digits = 4;
			MODE_XOR: digits = 2;
			default: digits = $urandom_range(0, 1) ? 2 : 4;
		endcase
		do wrong = $urandom_range(0, 6); while (wrong == digits);
		if (kind < 60) begin
			send_framed(body, digits, 1'b0, lower, 1'b1);
		end else if (kind < 70) begin
			send_framed(body, digits, 1'b1, lower, 1'b1);
		end else if (kind < 78) begin
			send_framed(body, wrong, 1'b0, lower, 1'b1);
		end else if (kind < 84) begin
			send_framed(body, digits, $urandom_range(0, 1), lower, 1'b0);
		end else if (kind < 90) begin
			send_line(body, 1'b1);
		end else if (kind < 97) begin
			send_line(random_body($urandom_range(0, 30), 1'b0, 1'b1), $urandom_range(0, 1));
		end else begin
			body = random_body($urandom_range(250, 300), 1'b1, 1'b0);
			body[0] = "$";
			send_framed(body, digits, 1'b0, lower, 1'b1);
		end
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_CHECK_MODE) board.mode = mode_t'(value[1:0]);
	endtask

	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles(SIDE_RX);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			board.check_verdict(res_ch.status, res_ch.computed_sum, res_ch.received_sum,
				res_ch.line_length);
		end
	end

	initial begin
		byte_q_t q;
		int phase_start;
		board = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_line(q, 1'b0);
		send_line(q, 1'b1);
		send_framed(to_bytes("$GPGGA,12.5,N"), 2, 1'b0, 1'b0, 1'b1);
		send_framed(to_bytes("$GPGGA,12.5,N"), 2, 1'b1, 1'b0, 1'b1);
		send_framed(to_bytes("$GPVTG,9"), 3, 1'b0, 1'b0, 1'b1);
		send_framed(to_bytes("$pqrz~"), 2, 1'b0, 1'b1, 1'b1);
		send_framed(to_bytes("$GPZDA"), 2, 1'b0, 1'b0, 1'b0);
		send_line(to_bytes("*00"), 1'b1);
		send_line(to_bytes("$AB*g1"), 1'b1);
		send_line(to_bytes("$X*123456"), 1'b1);
		q = '{8'h24, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE};
		send_framed(q, 2, 1'b0, 1'b0, 1'b1);
		send_line(random_body(254, 1'b0, 1'b0), 1'b1);
		send_line(random_body(255, 1'b0, 1'b0), 1'b1);

		wait_drained();
		write_reg(REG_UNUSED, MODE_CRC);
		send_framed(to_bytes("$GPRMC,A"), 2, 1'b0, 1'b0, 1'b1);

		foreach (PHASE_MODES[p]) begin
			wait_drained();
			write_reg(REG_CHECK_MODE, PHASE_MODES[p]);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) random_line();
		end

		wait_drained();
		if (board.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
